FILE: hdl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, sector codes and the divide-by-255 helper.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   // Number of register stages in the datapath.
   localparam int NSTAGES = 7;

   localparam logic [8:0] HUE_MOD     = 9'd360;
   localparam logic [7:0] FULL_SCALE  = 8'd255;
   // floor(2^24 / 360); the quotient estimate is low by at most one.
   localparam logic [15:0] HUE_RECIP  = 16'd46603;

   // Sector codes, one per 60-degree slice of the hue circle.
   localparam logic [2:0] SECTOR_R_TO_Y = 3'd0;
   localparam logic [2:0] SECTOR_Y_TO_G = 3'd1;
   localparam logic [2:0] SECTOR_G_TO_C = 3'd2;
   localparam logic [2:0] SECTOR_C_TO_B = 3'd3;
   localparam logic [2:0] SECTOR_B_TO_M = 3'd4;
   localparam logic [2:0] SECTOR_M_TO_R = 3'd5;

   // Truncating division by 255, exact for every operand up to 255 * 255.
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] acc;
      acc = 17'(x) + 17'(x[15:8]) + 17'd1;
      return acc[15:8];
   endfunction

endpackage

FILE: hdl/hsvrgb_pipe_ctl.sv
// ----------------------------------------------------------------------------
// HSV to RGB pipeline control
// Valid bits per stage and per-stage load enables; bubbles collapse on stall.
// ----------------------------------------------------------------------------
module hsvrgb_pipe_ctl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic                             out_ready,
   output logic                             in_ready,
   output logic                             out_valid,
   output logic [hsvrgb_pkg::NSTAGES-1:0]   stage_en
);

   logic [hsvrgb_pkg::NSTAGES-1:0] vld_ff;
   logic [hsvrgb_pkg::NSTAGES-1:0] vld_in;
   logic [hsvrgb_pkg::NSTAGES-1:0] en;

   // A stage may load when it is empty or when the stage after it moves on.
   always_comb begin
      en[hsvrgb_pkg::NSTAGES-1] = ~vld_ff[hsvrgb_pkg::NSTAGES-1] | out_ready;
      for (int k = hsvrgb_pkg::NSTAGES - 2; k >= 0; k--) begin
         en[k] = ~vld_ff[k] | en[k+1];
      end
   end

   always_comb begin
      vld_in[0] = en[0] ? in_valid : vld_ff[0];
      for (int k = 1; k < hsvrgb_pkg::NSTAGES; k++) begin
         vld_in[k] = en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign stage_en  = en;
   assign in_ready  = en[0];
   assign out_valid = vld_ff[hsvrgb_pkg::NSTAGES-1];

endmodule

FILE: hdl/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Converts a 16-bit hue, 8-bit saturation and 8-bit value to 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel carries one pixel per transaction: hue in degrees (any
// 16-bit value, reduced modulo 360 inside), saturation and brightness. The
// rsp_ channel returns one transaction with red, green and blue per pixel,
// in the order the pixels arrived.
// An accepted request reaches rsp_tvalid through the seven register stages
// of the datapath (reciprocal product, hue modulo, sector split, two multiply
// stages each followed by a divide-by-255, the last one with channel select).
// Throughput is one pixel per cycle while rsp_tready stays high.
// Reset empties the pipeline; no result is presented until new pixels are
// accepted. When the receiver stalls, the last stage holds its result and
// earlier stages keep filling any empty slots, so req_tready drops only
// once every stage holds a pixel. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red[7:0], green[15:8], blue[23:16]
);

   logic [hsvrgb_pkg::NSTAGES-1:0] stage_en;

   hsvrgb_pipe_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .out_ready (rsp_tready),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .stage_en  (stage_en)
   );

   logic [15:0] req_hue;
   logic [7:0]  req_saturation;
   logic [7:0]  req_brightness;

   assign req_hue        = req_tdata[15:0];
   assign req_saturation = req_tdata[23:16];
   assign req_brightness = req_tdata[31:24];

   // Stage 0: reciprocal product for hue / 360, and v * (255 - s) for p.
   logic [15:0] hue0_ff;
   logic [7:0]  sat0_ff, val0_ff;
   logic [31:0] hprod0_ff, hprod0_in;
   logic [15:0] pv0_ff, pv0_in;

   assign hprod0_in = 32'(req_hue) * 32'(hsvrgb_pkg::HUE_RECIP);
   assign pv0_in    = 16'(req_brightness) * 16'(hsvrgb_pkg::FULL_SCALE - req_saturation);

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         hue0_ff   <= req_hue;
         sat0_ff   <= req_saturation;
         val0_ff   <= req_brightness;
         hprod0_ff <= hprod0_in;
         pv0_ff    <= pv0_in;
      end
   end

   // Stage 1: hue modulo 360 with one correction step, and p.
   logic [7:0]  quo1;
   logic [16:0] wrap1;
   logic [16:0] raw1;
   logic [9:0]  rem1;
   logic [8:0]  hr1_ff, hr1_in;
   logic [7:0]  sat1_ff, val1_ff, p1_ff;

   always_comb begin
      quo1  = hprod0_ff[31:24];
      wrap1 = 17'(quo1) * 17'(hsvrgb_pkg::HUE_MOD);
      raw1  = 17'(hue0_ff) - wrap1;
      rem1  = raw1[9:0];
      if (rem1 >= 10'(hsvrgb_pkg::HUE_MOD)) begin
         hr1_in = 9'(rem1 - 10'(hsvrgb_pkg::HUE_MOD));
      end else begin
         hr1_in = rem1[8:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         hr1_ff  <= hr1_in;
         sat1_ff <= sat0_ff;
         val1_ff <= val0_ff;
         p1_ff   <= hsvrgb_pkg::div255(pv0_ff);
      end
   end

   // Stage 2: sector and position within it; 255/60 is exactly 17/4.
   logic [2:0] sec2_ff, sec2_in;
   logic [8:0] base2;
   logic [5:0] off2;
   logic [9:0] scaled2;
   logic [7:0] f2_ff, f2_in;
   logic [7:0] sat2_ff, val2_ff, p2_ff;

   always_comb begin
      if (hr1_ff < 9'd60) begin
         sec2_in = hsvrgb_pkg::SECTOR_R_TO_Y;
         base2   = 9'd0;
      end else if (hr1_ff < 9'd120) begin
         sec2_in = hsvrgb_pkg::SECTOR_Y_TO_G;
         base2   = 9'd60;
      end else if (hr1_ff < 9'd180) begin
         sec2_in = hsvrgb_pkg::SECTOR_G_TO_C;
         base2   = 9'd120;
      end else if (hr1_ff < 9'd240) begin
         sec2_in = hsvrgb_pkg::SECTOR_C_TO_B;
         base2   = 9'd180;
      end else if (hr1_ff < 9'd300) begin
         sec2_in = hsvrgb_pkg::SECTOR_B_TO_M;
         base2   = 9'd240;
      end else begin
         sec2_in = hsvrgb_pkg::SECTOR_M_TO_R;
         base2   = 9'd300;
      end
      off2    = 6'(hr1_ff - base2);
      scaled2 = 10'(off2) * 10'd17;
      f2_in   = scaled2[9:2];
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         sec2_ff <= sec2_in;
         f2_ff   <= f2_in;
         sat2_ff <= sat1_ff;
         val2_ff <= val1_ff;
         p2_ff   <= p1_ff;
      end
   end

   // Stage 3: s * f and s * (255 - f).
   logic [15:0] sf3_ff, sf3_in, sg3_ff, sg3_in;
   logic [2:0]  sec3_ff;
   logic [7:0]  val3_ff, p3_ff;

   assign sf3_in = 16'(sat2_ff) * 16'(f2_ff);
   assign sg3_in = 16'(sat2_ff) * 16'(hsvrgb_pkg::FULL_SCALE - f2_ff);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         sf3_ff  <= sf3_in;
         sg3_ff  <= sg3_in;
         sec3_ff <= sec2_ff;
         val3_ff <= val2_ff;
         p3_ff   <= p2_ff;
      end
   end

   // Stage 4: complement factors for q and t.
   logic [7:0] qa4_ff, ta4_ff;
   logic [2:0] sec4_ff;
   logic [7:0] val4_ff, p4_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         qa4_ff  <= hsvrgb_pkg::FULL_SCALE - hsvrgb_pkg::div255(sf3_ff);
         ta4_ff  <= hsvrgb_pkg::FULL_SCALE - hsvrgb_pkg::div255(sg3_ff);
         sec4_ff <= sec3_ff;
         val4_ff <= val3_ff;
         p4_ff   <= p3_ff;
      end
   end

   // Stage 5: scale by v.
   logic [15:0] qv5_ff, qv5_in, tv5_ff, tv5_in;
   logic [2:0]  sec5_ff;
   logic [7:0]  val5_ff, p5_ff;

   assign qv5_in = 16'(val4_ff) * 16'(qa4_ff);
   assign tv5_in = 16'(val4_ff) * 16'(ta4_ff);

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         qv5_ff  <= qv5_in;
         tv5_ff  <= tv5_in;
         sec5_ff <= sec4_ff;
         val5_ff <= val4_ff;
         p5_ff   <= p4_ff;
      end
   end

   // Stage 6: final divide and channel placement by sector.
   logic [7:0] q6, t6;
   logic [7:0] red6_ff, red6_in, green6_ff, green6_in, blue6_ff, blue6_in;

   always_comb begin
      q6 = hsvrgb_pkg::div255(qv5_ff);
      t6 = hsvrgb_pkg::div255(tv5_ff);
      case (sec5_ff)
         hsvrgb_pkg::SECTOR_R_TO_Y: begin
            red6_in = val5_ff; green6_in = t6;      blue6_in = p5_ff;
         end
         hsvrgb_pkg::SECTOR_Y_TO_G: begin
            red6_in = q6;      green6_in = val5_ff; blue6_in = p5_ff;
         end
         hsvrgb_pkg::SECTOR_G_TO_C: begin
            red6_in = p5_ff;   green6_in = val5_ff; blue6_in = t6;
         end
         hsvrgb_pkg::SECTOR_C_TO_B: begin
            red6_in = p5_ff;   green6_in = q6;      blue6_in = val5_ff;
         end
         hsvrgb_pkg::SECTOR_B_TO_M: begin
            red6_in = t6;      green6_in = p5_ff;   blue6_in = val5_ff;
         end
         default: begin
            red6_in = val5_ff; green6_in = p5_ff;   blue6_in = q6;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         red6_ff   <= red6_in;
         green6_ff <= green6_in;
         blue6_ff  <= blue6_in;
      end
   end

   assign rsp_tdata = {blue6_ff, green6_ff, red6_ff};

endmodule

FILE: hdl/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Port-level assertions on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hsvrgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [31:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   // A stalled result keeps its valid and its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // With no result waiting, every stage can advance, so a request is taken.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with an empty output stage");

   // When the output stage hands off its result, every stage behind it moves
   // on in the same cycle, so the input has room for a new request.
   a_ready_after_take: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> req_tready)
      else $error("request refused while the output advances");

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker u_hsvrgb_checker (.*);

FILE: dv/hsv_to_rgb_checker.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter checker
// Watches both stream channels, predicts the color of every accepted pixel
// and compares each returned transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module hsv_to_rgb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // red[7:0], green[15:8], blue[23:16]
   output int          mismatches,
   output int          outstanding,
   output int          colors_checked,
   output logic [5:0]  sectors_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_type;

   rgb_type expected_colors [$];

   function automatic rgb_type predict_rgb(input logic [15:0] hue, input logic [7:0] sat,
                                           input logic [7:0] bri);
      int unsigned h, sector, frac, v, s, p, q, t;
      rgb_type     c;
      v      = 32'(bri);
      s      = 32'(sat);
      h      = 32'(hue) % 360;
      sector = h / 60;
      frac   = ((h % 60) * 255) / 60;
      p      = (v * (255 - s)) / 255;
      q      = (v * (255 - (s * frac) / 255)) / 255;
      t      = (v * (255 - (s * (255 - frac)) / 255)) / 255;
      case (3'(sector))
         hsvrgb_pkg::SECTOR_R_TO_Y: begin
            c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p);
         end
         hsvrgb_pkg::SECTOR_Y_TO_G: begin
            c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p);
         end
         hsvrgb_pkg::SECTOR_G_TO_C: begin
            c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t);
         end
         hsvrgb_pkg::SECTOR_C_TO_B: begin
            c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v);
         end
         hsvrgb_pkg::SECTOR_B_TO_M: begin
            c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v);
         end
         default: begin
            c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q);
         end
      endcase
      return c;
   endfunction

   initial begin
      mismatches     = 0;
      outstanding    = 0;
      colors_checked = 0;
      sectors_seen   = '0;
   end

   always @(posedge clock) begin : watch
      rgb_type    want;
      rgb_type    got;
      logic [7:0] want_ch [3];
      logic [7:0] got_ch  [3];
      string      ch_name [3];
      bit         bad;
      ch_name = '{"red", "green", "blue"};
      if (!reset) begin
         // Results leave before new pixels are queued; a pixel accepted in this
         // cycle cannot be the one that is returned in the same cycle.
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_colors.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected result, expected none, actual %06h",
                        $time, rsp_tdata);
            end else begin
               want = expected_colors.pop_front();
               want_ch = '{want.red, want.green, want.blue};
               got_ch  = '{got.red, got.green, got.blue};
               bad = 1'b0;
               for (int i = 0; i < 3; i++) begin
                  if (want_ch[i] !== got_ch[i]) begin
                     bad = 1'b1;
                     $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                              $time, ch_name[i], want_ch[i], got_ch[i]);
                  end
               end
               if (bad)
                  mismatches++;
               colors_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_colors.push_back(predict_rgb(req_tdata[15:0], req_tdata[23:16],
                                                  req_tdata[31:24]));
            sectors_seen[3'((req_tdata[15:0] % 16'd360) / 16'd60)] <= 1'b1;
         end
      end
      outstanding <= expected_colors.size();
   end

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives directed and random pixels through the converter under changing
// backpressure and lets the checker compare every returned color.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 650;
   localparam int STALL_CYCLES  = 48;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // hue[15:0], saturation[23:16], brightness[31:24]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // red[7:0], green[15:8], blue[23:16]

   int         mismatches;
   int         outstanding;
   int         colors_checked;
   logic [5:0] sectors_seen;

   int pixels_sent;
   int send_idle_pct;
   int recv_idle_pct;
   bit long_stall_req;
   bit long_stall_done;

   hsv_to_rgb_converter_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hsv_to_rgb_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .colors_checked (colors_checked),
      .sectors_seen   (sectors_seen)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results still outstanding", outstanding);
      $display("TEST FAILED");
      $finish;
   end

   // Receiver: random backpressure, plus one long hold-off on request.
   initial begin
      rsp_tready      = 1'b0;
      long_stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_req && !long_stall_done) begin
            long_stall_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_pixel(input logic [15:0] hue, input logic [7:0] sat,
                             input logic [7:0] bri);
      req_tvalid <= 1'b1;
      req_tdata  <= {bri, sat, hue};
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [7:0] random_level();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [15:0] random_hue();
      int unsigned edge_pick;
      case ($urandom_range(3))
         0: return 16'($urandom_range(359));
         1: return 16'($urandom_range(65535));
         2: begin
            // Land on or next to a sector boundary, sometimes wrapped past 360.
            edge_pick = 60 * $urandom_range(5) + (($urandom_range(1)) ? 0 : 59)
                        + ($urandom_range(1) ? 1 : 0);
            return 16'(edge_pick + 360 * $urandom_range(180));
         end
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_pixel(random_hue(), random_level(), random_level());
   endtask

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      pixels_sent    = 0;
      send_idle_pct  = 22;
      recv_idle_pct  = 83;
      long_stall_req = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed pixels: field extremes, every sector, grey and wrapped hues.
      send_pixel(16'd0,     8'd255, 8'd255);
      send_pixel(16'd59,    8'd255, 8'd255);
      send_pixel(16'd60,    8'd255, 8'd255);
      send_pixel(16'd119,   8'd200, 8'd255);
      send_pixel(16'd120,   8'd255, 8'd128);
      send_pixel(16'd180,   8'd255, 8'd255);
      send_pixel(16'd239,   8'd1,   8'd254);
      send_pixel(16'd240,   8'd255, 8'd255);
      send_pixel(16'd300,   8'd255, 8'd255);
      send_pixel(16'd330,   8'd128, 8'd200);
      send_pixel(16'd359,   8'd255, 8'd255);
      send_pixel(16'd360,   8'd255, 8'd255);
      send_pixel(16'd719,   8'd255, 8'd100);
      send_pixel(16'd65535, 8'd255, 8'd255);
      send_pixel(16'd65535, 8'd0,   8'd0);
      send_pixel(16'd90,    8'd0,   8'd255);
      send_pixel(16'd200,   8'd0,   8'd77);
      send_pixel(16'd45,    8'd255, 8'd0);
      send_pixel(16'd270,   8'd170, 8'd85);
      send_pixel(16'd32768, 8'd85,  8'd170);
      send_pixel(16'd1,     8'd254, 8'd1);
      send_pixel(16'd299,   8'd255, 8'd255);

      // Sender idles lightly, receiver heavily.
      send_random(RANDOM_PIXELS / 3);

      // Sender idles heavily, receiver lightly.
      send_idle_pct = 83;
      recv_idle_pct = 22;
      send_random(RANDOM_PIXELS / 3);

      // No idling; a long receiver hold-off fills the pipeline and stalls input.
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      long_stall_req = 1'b1;
      send_random(40);
      wait_until_drained();
      send_random(RANDOM_PIXELS - 2 * (RANDOM_PIXELS / 3) - 40);

      wait_until_drained();
      repeat (2 * hsvrgb_pkg::NSTAGES + 4) @(posedge clock);

      $display("Sent %0d pixels (sector mask %06b) under three backpressure mixes",
               pixels_sent, sectors_seen);
      $display("Compared %0d colors, %0d with mismatches", colors_checked, mismatches);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_pipe_ctl.sv
hdl/hsv_to_rgb_converter_unit.sv
hdl/hsvrgb_checker.sv
dv/hsv_to_rgb_checker.sv
dv/tb_top.sv
